// File: rtl/priority_round_robin_thread_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// assertion on an explicit clock and active-low reset
`define PRTS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion on the block clock and reset
`define PRTS_ASSERT(lbl, prop, msg) `PRTS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define PRTS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define PRTS_ASSERT(lbl, prop, msg)
`endif
`endif

// File: rtl/prts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Word types, operation and status codes, and controller commands.
// ----------------------------------------------------------------------------
package prts_pkg;

    localparam int MAX_SLOTS_DEF = 16;

    // operation codes of the input word
    localparam logic [2:0] M_TICK     = 3'd0;
    localparam logic [2:0] M_SCHEDULE = 3'd1;
    localparam logic [2:0] M_ADD      = 3'd2;
    localparam logic [2:0] M_KILL_ID  = 3'd3;
    localparam logic [2:0] M_KILL_SELF= 3'd4;
    localparam logic [2:0] M_SLEEP    = 3'd5;
    localparam logic [2:0] M_BLOCK    = 3'd6;
    localparam logic [2:0] M_LAUNCH   = 3'd7;

    // status codes of the result word
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIMIT    = 2'd1;
    localparam logic [1:0] ST_LAST     = 2'd2;
    localparam logic [1:0] ST_NO_THREAD= 2'd3;

    // datapath commands
    localparam logic [4:0] C_NOP        = 5'd0;
    localparam logic [4:0] C_LOAD       = 5'd1;
    localparam logic [4:0] C_ERR        = 5'd2;
    localparam logic [4:0] C_TICK_EV    = 5'd3;
    localparam logic [4:0] C_SKIP       = 5'd4;
    localparam logic [4:0] C_SCHED_EV   = 5'd5;
    localparam logic [4:0] C_SCHED_END  = 5'd6;
    localparam logic [4:0] C_ADD_LINK   = 5'd7;
    localparam logic [4:0] C_ADD_FIN    = 5'd8;
    localparam logic [4:0] C_FIND_EV    = 5'd9;
    localparam logic [4:0] C_SELF_EV    = 5'd10;
    localparam logic [4:0] C_UNLINK1    = 5'd11;
    localparam logic [4:0] C_UNLINK2    = 5'd12;
    localparam logic [4:0] C_SLEEP_EV   = 5'd13;
    localparam logic [4:0] C_BLOCK      = 5'd14;
    localparam logic [4:0] C_LAUNCH_EV  = 5'd15;
    localparam logic [4:0] C_LAUNCH_END = 5'd16;
    localparam logic [4:0] C_FIN_SEL    = 5'd17;
    localparam logic [4:0] C_OUT        = 5'd18;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  priority_req;
        logic [15:0] target_id;
        logic [31:0] sleep_ms;
        logic        blocked_value;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  running_slot;
        logic [15:0] running_id;
        logic [1:0]  status;
        logic [4:0]  thread_count;
        logic [15:0] assigned_id;
        logic        switch_request;
        logic        none_ready;
        logic [31:0] time_now;
    } t_out_word;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] err;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       live_zero;
        logic       live_le1;
        logic       live_full;
        logic       cur_alive;
        logic       last_idx;
        logic       walk_done;
        logic       hit;
    } t_dp_stat;

endpackage

// File: rtl/priority_round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Priority round-robin thread scheduler
// Thread table over a ring of slots: add, kill, sleep, block, tick, schedule.
// ----------------------------------------------------------------------------
// channel   ports                    word        handshake
// command   start, busy, i_item      t_in_word   taken when start & !busy
// result    o_valid, o_result        t_out_word  one-cycle strobe, no stall
//
// One word at a time. The walk over the slot RAMs reads each slot, then
// evaluates it; busy stays high while the walk runs, and the strobe comes
// in the cycle in which busy drops: tick and launch visit every slot,
// schedule and id lookups visit the live ring. The result strobes while
// the next word may be taken.
// Reset clears flags and counters at once; the slot RAMs need no clearing.
// ----------------------------------------------------------------------------
`include "priority_round_robin_thread_scheduler_assert.svh"

module priority_round_robin_thread_scheduler #(
    parameter int MAX_SLOTS = prts_pkg::MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  prts_pkg::t_in_word  i_item,
    output logic                o_valid,
    output prts_pkg::t_out_word o_result
);
    import prts_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    prts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    prts_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // an accepted word keeps the controller busy
    `PRTS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "word accepted but not busy")
    // one result word per operation, never two in a row
    `PRTS_ASSERT(a_single_strobe, o_valid |=> !o_valid, "result strobe held")
    // a result only follows a busy cycle
    `PRTS_ASSERT(a_strobe_after_busy, o_valid |-> $past(busy), "result without operation")
    // failed operations hand out no id
    `PRTS_ASSERT(a_fail_no_id, (o_valid && (o_result.status != ST_OK)) |->
        (o_result.assigned_id == 16'd0), "id assigned on failure")

endmodule

// File: rtl/prts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/prts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one operation at a time as commands to the datapath.
// ----------------------------------------------------------------------------
module prts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  prts_pkg::t_dp_stat i_stat,
    output prts_pkg::t_dp_cmd  o_cmd
);
    import prts_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_EV    = 4'd3;
    localparam logic [3:0] S_SKIPW = 4'd4;
    localparam logic [3:0] S_SKIP  = 4'd5;
    localparam logic [3:0] S_ADD2  = 4'd6;
    localparam logic [3:0] S_UNL1  = 4'd7;
    localparam logic [3:0] S_UNL2  = 4'd8;
    localparam logic [3:0] S_BLK   = 4'd9;
    localparam logic [3:0] S_END   = 4'd10;
    localparam logic [3:0] S_FSEL  = 4'd11;
    localparam logic [3:0] S_FWAIT = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and command
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = C_NOP;
        o_cmd.err = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = C_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_WAIT;
                case (i_stat.mode)
                    M_SCHEDULE: begin
                        if (i_stat.live_zero) begin
                            n_state = S_END;
                        end else if (i_stat.cur_alive) begin
                            n_state = S_SKIPW;
                        end
                    end
                    M_ADD: begin
                        if (i_stat.live_full) begin
                            o_cmd.op  = C_ERR;
                            o_cmd.err = ST_LIMIT;
                            n_state   = S_FSEL;
                        end
                    end
                    M_KILL_ID: begin
                        if (i_stat.live_le1) begin
                            o_cmd.op  = C_ERR;
                            o_cmd.err = ST_LAST;
                            n_state   = S_FSEL;
                        end
                    end
                    M_KILL_SELF: begin
                        if (i_stat.live_le1) begin
                            o_cmd.op  = C_ERR;
                            o_cmd.err = ST_LAST;
                            n_state   = S_FSEL;
                        end else if (!i_stat.cur_alive) begin
                            o_cmd.op  = C_ERR;
                            o_cmd.err = ST_NO_THREAD;
                            n_state   = S_FSEL;
                        end
                    end
                    M_SLEEP: begin
                        if (!i_stat.cur_alive) begin
                            o_cmd.op  = C_ERR;
                            o_cmd.err = ST_NO_THREAD;
                            n_state   = S_FSEL;
                        end
                    end
                    M_BLOCK: begin
                        if (i_stat.live_zero) begin
                            o_cmd.op  = C_ERR;
                            o_cmd.err = ST_NO_THREAD;
                            n_state   = S_FSEL;
                        end
                    end
                    default: begin
                        n_state = S_WAIT;
                    end
                endcase
            end
            S_WAIT: begin
                n_state = S_EV;
            end
            S_SKIPW: begin
                n_state = S_SKIP;
            end
            S_SKIP: begin
                o_cmd.op = C_SKIP;
                n_state  = S_WAIT;
            end
            // slot data for r_p is valid here
            S_EV: begin
                case (i_stat.mode)
                    M_TICK: begin
                        o_cmd.op = C_TICK_EV;
                        n_state  = i_stat.last_idx ? S_FSEL : S_WAIT;
                    end
                    M_SCHEDULE: begin
                        o_cmd.op = C_SCHED_EV;
                        n_state  = i_stat.walk_done ? S_END : S_WAIT;
                    end
                    M_ADD: begin
                        o_cmd.op = C_ADD_LINK;
                        n_state  = S_ADD2;
                    end
                    M_KILL_ID: begin
                        o_cmd.op = C_FIND_EV;
                        if (i_stat.hit) begin
                            n_state = S_UNL1;
                        end else begin
                            n_state = i_stat.walk_done ? S_END : S_WAIT;
                        end
                    end
                    M_KILL_SELF: begin
                        o_cmd.op = C_SELF_EV;
                        n_state  = S_UNL1;
                    end
                    M_SLEEP: begin
                        o_cmd.op = C_SLEEP_EV;
                        n_state  = S_FSEL;
                    end
                    M_BLOCK: begin
                        o_cmd.op = C_FIND_EV;
                        if (i_stat.hit) begin
                            n_state = S_BLK;
                        end else begin
                            n_state = i_stat.walk_done ? S_END : S_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.op = C_LAUNCH_EV;
                        n_state  = i_stat.last_idx ? S_END : S_WAIT;
                    end
                endcase
            end
            S_ADD2: begin
                o_cmd.op = C_ADD_FIN;
                n_state  = S_FSEL;
            end
            S_UNL1: begin
                o_cmd.op = C_UNLINK1;
                n_state  = S_UNL2;
            end
            S_UNL2: begin
                o_cmd.op = C_UNLINK2;
                n_state  = S_FSEL;
            end
            S_BLK: begin
                o_cmd.op = C_BLOCK;
                n_state  = S_FSEL;
            end
            S_END: begin
                n_state = S_FSEL;
                case (i_stat.mode)
                    M_SCHEDULE: o_cmd.op = C_SCHED_END;
                    M_LAUNCH:   o_cmd.op = C_LAUNCH_END;
                    default: begin
                        o_cmd.op  = C_ERR;
                        o_cmd.err = ST_NO_THREAD;
                    end
                endcase
            end
            S_FSEL: begin
                o_cmd.op = C_FIN_SEL;
                n_state  = S_FWAIT;
            end
            S_FWAIT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.op = C_OUT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/prts_dp.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot RAMs, slot flags, walk pointer and scheduler registers.
// ----------------------------------------------------------------------------
module prts_dp #(
    parameter int MAX_SLOTS = prts_pkg::MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prts_pkg::t_in_word  i_item,
    input  prts_pkg::t_dp_cmd   i_cmd,
    output prts_pkg::t_dp_stat  o_stat,
    output logic                o_valid,
    output prts_pkg::t_out_word o_result
);
    import prts_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int LW = $clog2(MAX_SLOTS + 1);

    // input word and flags
    t_in_word             r_in;
    logic [MAX_SLOTS-1:0] r_alive, r_asleep, r_blocked;
    logic [SW-1:0]        r_cur, r_ads;
    logic [LW-1:0]        r_live;
    logic [15:0]          r_idc;
    logic [31:0]          r_time;

    // walk registers
    logic [SW-1:0] r_p, r_k, r_n, r_pv, r_best_slot;
    logic [7:0]    r_best;
    logic          r_found;
    logic [LW-1:0] r_i;

    // result registers
    logic [1:0]  r_status;
    logic        r_sw, r_none;
    logic [15:0] r_assigned;
    logic        r_valid;
    t_out_word   r_res;

    // RAM ports
    logic          nx_we, pv_we, pr_we, wk_we, id_we;
    logic [SW-1:0] nx_wa, pv_wa, pr_wa, wk_wa, id_wa;
    logic [SW-1:0] nx_wd, pv_wd;
    logic [7:0]    pr_wd;
    logic [31:0]   wk_wd;
    logic [15:0]   id_wd;
    logic [SW-1:0] next_q, prev_q;
    logic [7:0]    prio_q;
    logic [31:0]   wake_q;
    logic [15:0]   id_q;

    logic [SW-1:0] free_slot, anchor;
    logic          cur_alive, live_zero, p_ready, hit;

    prts_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(r_p), .o_rdata(next_q)
    );
    prts_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(r_p), .o_rdata(prev_q)
    );
    prts_ram #(.WIDTH(8), .DEPTH(MAX_SLOTS)) u_prio (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_wa), .i_wdata(pr_wd),
        .i_raddr(r_p), .o_rdata(prio_q)
    );
    prts_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_wake (
        .i_clk(i_clk), .i_we(wk_we), .i_waddr(wk_wa), .i_wdata(wk_wd),
        .i_raddr(r_p), .o_rdata(wake_q)
    );
    prts_ram #(.WIDTH(16), .DEPTH(MAX_SLOTS)) u_id (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(id_wa), .i_wdata(id_wd),
        .i_raddr(r_p), .o_rdata(id_q)
    );

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
            if (!r_alive[j]) begin
                free_slot = SW'(j);
            end
        end
    end

    assign cur_alive = r_alive[r_cur];
    assign anchor    = cur_alive ? r_cur : r_ads;
    assign live_zero = (r_live == '0);
    assign p_ready   = r_alive[r_p] & ~r_asleep[r_p] & ~r_blocked[r_p];
    assign hit       = r_alive[r_p] && (id_q == r_in.target_id);

    // status to controller
    always_comb begin
        o_stat.mode      = r_in.mode;
        o_stat.live_zero = live_zero;
        o_stat.live_le1  = (r_live <= LW'(1));
        o_stat.live_full = (r_live >= LW'(MAX_SLOTS));
        o_stat.cur_alive = cur_alive;
        o_stat.last_idx  = (r_p == SW'(MAX_SLOTS - 1));
        o_stat.walk_done = (LW'(r_i + 1'b1) == r_live);
        o_stat.hit       = hit;
    end

    // RAM writes
    always_comb begin
        nx_we = 1'b0; nx_wa = r_k; nx_wd = r_k;
        pv_we = 1'b0; pv_wa = r_k; pv_wd = r_k;
        pr_we = 1'b0; pr_wa = r_k; pr_wd = r_in.priority_req;
        wk_we = 1'b0; wk_wa = r_p; wk_wd = r_time + r_in.sleep_ms;
        id_we = 1'b0; id_wa = r_k; id_wd = r_idc;
        case (i_cmd.op)
            C_ADD_LINK: begin
                nx_we = 1'b1;
                nx_wd = live_zero ? r_k : r_p;
                pv_we = 1'b1;
                pv_wd = live_zero ? r_k : prev_q;
            end
            C_ADD_FIN: begin
                nx_we = !live_zero;
                nx_wa = r_pv;
                pv_we = !live_zero;
                pv_wa = r_p;
                pr_we = 1'b1;
                id_we = 1'b1;
            end
            C_UNLINK1: begin
                nx_we = 1'b1;
                nx_wa = r_pv;
                nx_wd = r_n;
                pv_we = 1'b1;
                pv_wa = r_n;
                pv_wd = r_pv;
            end
            C_UNLINK2: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            C_SLEEP_EV: begin
                wk_we = 1'b1;
            end
            default: begin
                nx_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive   <= '0;
            r_asleep  <= '0;
            r_blocked <= '0;
            r_cur     <= '0;
            r_ads     <= '0;
            r_live    <= '0;
            r_idc     <= '0;
            r_time    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == C_OUT);
            case (i_cmd.op)
                C_LOAD: begin
                    if (i_item.mode == M_TICK) begin
                        r_time <= r_time + 32'd1;
                    end
                end
                C_TICK_EV: begin
                    if (r_alive[r_p] && r_asleep[r_p] && (wake_q == r_time)) begin
                        r_asleep[r_p] <= 1'b0;
                    end
                end
                C_SCHED_END: begin
                    if (r_found) begin
                        r_cur <= r_best_slot;
                    end
                end
                C_ADD_FIN: begin
                    r_alive[r_k]   <= 1'b1;
                    r_asleep[r_k]  <= 1'b0;
                    r_blocked[r_k] <= 1'b0;
                    r_idc          <= r_idc + 16'd1;
                    r_live         <= r_live + LW'(1);
                end
                C_UNLINK1: begin
                    if ((r_k == r_cur) || (!cur_alive && (r_k == r_ads))) begin
                        r_ads <= r_n;
                    end
                    r_alive[r_k] <= 1'b0;
                    r_live       <= r_live - LW'(1);
                end
                C_SLEEP_EV: begin
                    r_asleep[r_p] <= 1'b1;
                    r_ads         <= next_q;
                end
                C_BLOCK: begin
                    r_blocked[r_k] <= r_in.blocked_value;
                end
                C_LAUNCH_END: begin
                    r_cur <= r_found ? r_best_slot : '0;
                end
                default: begin
                end
            endcase
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            C_LOAD: begin
                r_in       <= i_item;
                r_k        <= free_slot;
                r_p        <= ((i_item.mode == M_TICK) || (i_item.mode == M_LAUNCH)) ?
                              '0 : anchor;
                r_i        <= '0;
                r_found    <= 1'b0;
                r_status   <= ST_OK;
                r_sw       <= (i_item.mode == M_TICK);
                r_none     <= 1'b0;
                r_assigned <= '0;
            end
            C_ERR: begin
                r_status <= i_cmd.err;
            end
            C_TICK_EV, C_LAUNCH_EV: begin
                if ((i_cmd.op == C_LAUNCH_EV) && r_alive[r_p] &&
                    (!r_found || (prio_q < r_best))) begin
                    r_best      <= prio_q;
                    r_best_slot <= r_p;
                    r_found     <= 1'b1;
                end
                r_p <= r_p + SW'(1);
            end
            C_SKIP: begin
                r_p <= next_q;
            end
            C_SCHED_EV: begin
                if (p_ready && (!r_found || (prio_q < r_best))) begin
                    r_best      <= prio_q;
                    r_best_slot <= r_p;
                    r_found     <= 1'b1;
                end
                r_p <= next_q;
                r_i <= r_i + LW'(1);
            end
            C_SCHED_END: begin
                r_none <= !r_found;
            end
            C_ADD_LINK: begin
                r_pv <= prev_q;
            end
            C_ADD_FIN: begin
                r_assigned <= r_idc;
            end
            C_FIND_EV, C_SELF_EV: begin
                if (hit || (i_cmd.op == C_SELF_EV)) begin
                    r_k  <= r_p;
                    r_n  <= next_q;
                    r_pv <= prev_q;
                end else begin
                    r_p <= next_q;
                    r_i <= r_i + LW'(1);
                end
            end
            C_UNLINK1: begin
                r_sw <= (r_k == r_cur);
            end
            C_SLEEP_EV: begin
                r_sw <= 1'b1;
            end
            C_FIN_SEL: begin
                r_p <= r_cur;
            end
            C_OUT: begin
                r_res.running_slot   <= 4'(r_cur);
                r_res.running_id     <= cur_alive ? id_q : 16'd0;
                r_res.status         <= r_status;
                r_res.thread_count   <= 5'(r_live);
                r_res.assigned_id    <= r_assigned;
                r_res.switch_request <= r_sw;
                r_res.none_ready     <= r_none;
                r_res.time_now       <= r_time;
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// File: sim/priority_round_robin_thread_scheduler_test.sv
// ----------------------------------------------------------------------------
// Thread scheduler testbench
// Drives command words through the start/busy handshake, predicts each result
// word with a behavioral copy of the slot ring, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module priority_round_robin_thread_scheduler_test;
    import prts_pkg::*;

    localparam int NSLOT = 16;
    localparam int LIMIT_NS = 3_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_item;
    logic      o_valid;
    t_out_word o_result;

    priority_round_robin_thread_scheduler #(.MAX_SLOTS(NSLOT)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // predicted copy of the thread table
    logic [3:0]  ring_next [NSLOT];
    logic [3:0]  ring_prev [NSLOT];
    logic [7:0]  prio_tab  [NSLOT];
    logic        alive     [NSLOT];
    logic        asleep    [NSLOT];
    logic        blocked   [NSLOT];
    logic [31:0] wake_at   [NSLOT];
    logic [15:0] tid_tab   [NSLOT];
    logic [3:0]  cur_slot;
    logic [3:0]  dead_anchor;
    int          live_n;
    logic [15:0] id_next;
    logic [31:0] sys_time;

    t_out_word pending_words[$];
    int        errors;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [3:0] anchor_slot();
        return alive[cur_slot] ? cur_slot : dead_anchor;
    endfunction

    function automatic bit lookup_id(input logic [15:0] id, output logic [3:0] where);
        logic [3:0] p;
        p = anchor_slot();
        for (int i = 0; i < live_n && i < NSLOT; i++) begin
            if (alive[p] && tid_tab[p] == id) begin
                where = p;
                return 1;
            end
            p = ring_next[p];
        end
        return 0;
    endfunction

    function automatic void unlink(input logic [3:0] k);
        logic [3:0] n, p;
        n = ring_next[k];
        p = ring_prev[k];
        if (k == cur_slot || (!alive[cur_slot] && k == dead_anchor))
            dead_anchor = n;
        ring_next[p] = n;
        ring_prev[n] = p;
        ring_next[k] = k;
        ring_prev[k] = k;
        alive[k] = 1'b0;
        live_n--;
    endfunction

    // work out the result word of one command word and update the table
    function automatic t_out_word predict_word(input t_in_word w);
        t_out_word r;
        logic [1:0] st;
        logic [15:0] asg;
        logic sw, none;
        logic [3:0] k, p, start_p, a;
        logic [7:0] best;
        bit found;
        st = ST_OK; asg = '0; sw = 0; none = 0;
        case (w.mode)
            M_TICK: begin
                sys_time++;
                for (int s = 0; s < NSLOT; s++)
                    if (alive[s] && asleep[s] && wake_at[s] == sys_time) asleep[s] = 0;
                sw = 1;
            end
            M_SCHEDULE: begin
                if (live_n == 0) none = 1;
                else begin
                    start_p = alive[cur_slot] ? ring_next[cur_slot] : dead_anchor;
                    p = start_p; found = 0; best = '0;
                    for (int i = 0; i < live_n && i < NSLOT; i++) begin
                        if (alive[p] && !asleep[p] && !blocked[p] && (!found || prio_tab[p] < best)) begin
                            best = prio_tab[p];
                            found = 1;
                        end
                        p = ring_next[p];
                    end
                    if (!found) none = 1;
                    else begin
                        p = start_p;
                        for (int i = 0; i < NSLOT; i++) begin
                            if (alive[p] && !asleep[p] && !blocked[p] && prio_tab[p] == best) break;
                            p = ring_next[p];
                        end
                        cur_slot = p;
                    end
                end
            end
            M_ADD: begin
                if (live_n >= NSLOT) st = ST_LIMIT;
                else begin
                    k = '0;
                    for (int s = NSLOT - 1; s >= 0; s--) if (!alive[s]) k = 4'(s);
                    if (live_n == 0) begin
                        ring_next[k] = k;
                        ring_prev[k] = k;
                    end else begin
                        a = anchor_slot();
                        p = ring_prev[a];
                        ring_next[k] = a;
                        ring_prev[k] = p;
                        ring_next[p] = k;
                        ring_prev[a] = k;
                    end
                    prio_tab[k] = w.priority_req;
                    alive[k] = 1; asleep[k] = 0; blocked[k] = 0;
                    tid_tab[k] = id_next;
                    asg = id_next;
                    id_next++;
                    live_n++;
                end
            end
            M_KILL_ID: begin
                if (live_n <= 1) st = ST_LAST;
                else if (!lookup_id(w.target_id, k)) st = ST_NO_THREAD;
                else begin
                    sw = (k == cur_slot);
                    unlink(k);
                end
            end
            M_KILL_SELF: begin
                if (live_n <= 1) st = ST_LAST;
                else if (!alive[cur_slot]) st = ST_NO_THREAD;
                else begin
                    unlink(cur_slot);
                    sw = 1;
                end
            end
            M_SLEEP: begin
                if (!alive[cur_slot]) st = ST_NO_THREAD;
                else begin
                    wake_at[cur_slot] = sys_time + w.sleep_ms;
                    asleep[cur_slot] = 1;
                    dead_anchor = ring_next[cur_slot];
                    sw = 1;
                end
            end
            M_BLOCK: begin
                if (!lookup_id(w.target_id, k)) st = ST_NO_THREAD;
                else blocked[k] = w.blocked_value;
            end
            default: begin
                found = 0; k = '0;
                for (int s = 0; s < NSLOT; s++)
                    if (alive[s] && (!found || prio_tab[s] < prio_tab[k])) begin
                        k = 4'(s);
                        found = 1;
                    end
                cur_slot = found ? k : 4'd0;
            end
        endcase
        r.running_slot   = cur_slot;
        r.running_id     = alive[cur_slot] ? tid_tab[cur_slot] : 16'd0;
        r.status         = st;
        r.thread_count   = live_n[4:0];
        r.assigned_id    = asg;
        r.switch_request = sw;
        r.none_ready     = none;
        r.time_now       = sys_time;
        return r;
    endfunction

    // result checker
    initial begin
        t_out_word e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid) begin
                if (pending_words.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    e = pending_words.pop_front();
                    if (o_result.running_slot !== e.running_slot) begin
                        $error("running_slot exp %0d got %0d", e.running_slot, o_result.running_slot);
                        errors++;
                    end
                    if (o_result.running_id !== e.running_id) begin
                        $error("running_id exp %0d got %0d", e.running_id, o_result.running_id);
                        errors++;
                    end
                    if (o_result.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_result.status);
                        errors++;
                    end
                    if (o_result.thread_count !== e.thread_count) begin
                        $error("thread_count exp %0d got %0d", e.thread_count, o_result.thread_count);
                        errors++;
                    end
                    if (o_result.assigned_id !== e.assigned_id) begin
                        $error("assigned_id exp %0d got %0d", e.assigned_id, o_result.assigned_id);
                        errors++;
                    end
                    if (o_result.switch_request !== e.switch_request) begin
                        $error("switch_request exp %0d got %0d", e.switch_request,
                               o_result.switch_request);
                        errors++;
                    end
                    if (o_result.none_ready !== e.none_ready) begin
                        $error("none_ready exp %0d got %0d", e.none_ready, o_result.none_ready);
                        errors++;
                    end
                    if (o_result.time_now !== e.time_now) begin
                        $error("time_now exp %0d got %0d", e.time_now, o_result.time_now);
                        errors++;
                    end
                end
            end
        end
    end

    // send one command word after a random gap; start stays high between
    // back-to-back words and drops only for a gap
    task automatic send_word(input logic [2:0] mode, input logic [7:0] pr,
                             input logic [15:0] id, input logic [31:0] dur,
                             input logic bv, input bit no_gap = 0);
        t_in_word w;
        int gap;
        w.mode = mode; w.priority_req = pr; w.target_id = id;
        w.sleep_ms = dur; w.blocked_value = bv;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_words.push_back(predict_word(w));
    endtask

    // random word field helpers
    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8 && id_next > 0) return 16'(id_next - 1 - $urandom_range(0, 20));
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        // empty table corner cases
        send_word(M_SCHEDULE, 0, 0, 0, 0);
        send_word(M_LAUNCH, 0, 0, 0, 0);
        send_word(M_KILL_SELF, 0, 0, 0, 0);
        send_word(M_KILL_ID, 0, 0, 0, 0);
        send_word(M_SLEEP, 0, 0, 32'hFFFF_FFFF, 0);
        send_word(M_BLOCK, 0, 16'hFFFF, 0, 1);
        send_word(M_TICK, 0, 0, 0, 0);
        // first add, then kill of the last thread
        send_word(M_ADD, 8'hFF, 0, 0, 0);
        send_word(M_KILL_ID, 0, 0, 0, 0);
        send_word(M_LAUNCH, 0, 0, 0, 0);
        send_word(M_ADD, 8'h00, 0, 0, 0);
        send_word(M_ADD, 8'h80, 0, 0, 0);
        send_word(M_SCHEDULE, 0, 0, 0, 0);
        send_word(M_BLOCK, 0, 16'd1, 0, 1);
        send_word(M_SCHEDULE, 0, 0, 0, 0);
        send_word(M_KILL_ID, 0, 16'hBEEF, 0, 0);
        send_word(M_SLEEP, 0, 0, 32'd2, 0);
        send_word(M_SCHEDULE, 0, 0, 0, 0);
        send_word(M_TICK, 0, 0, 0, 0);
        send_word(M_TICK, 0, 0, 0, 0);
        send_word(M_SCHEDULE, 0, 0, 0, 0);
        send_word(M_KILL_SELF, 0, 0, 0, 0);
        send_word(M_SCHEDULE, 0, 0, 0, 0);
        // fill the table past its limit
        repeat (NSLOT) send_word(M_ADD, 8'($urandom), 0, 0, 0, 1);
    endtask

    task automatic test_random(input int n);
        int r;
        logic [31:0] dur;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
            if (r < 22)      send_word(M_TICK, 8'($urandom), 16'($urandom), $urandom,
                                       1'($urandom), $urandom_range(0, 3) == 0);
            else if (r < 44) send_word(M_SCHEDULE, 8'($urandom), 16'($urandom), $urandom,
                                       1'($urandom));
            else if (r < 58) send_word(M_ADD, 8'($urandom), 16'($urandom), $urandom,
                                       1'($urandom));
            else if (r < 66) send_word(M_KILL_ID, 8'($urandom), pick_id(), $urandom,
                                       1'($urandom));
            else if (r < 72) send_word(M_KILL_SELF, 8'($urandom), 16'($urandom), $urandom,
                                       1'($urandom));
            else if (r < 82) send_word(M_SLEEP, 8'($urandom), 16'($urandom), dur,
                                       1'($urandom));
            else if (r < 95) send_word(M_BLOCK, 8'($urandom), pick_id(), $urandom,
                                       1'($urandom));
            else             send_word(M_LAUNCH, 8'($urandom), 16'($urandom), $urandom,
                                       1'($urandom));
        end
    endtask

    // main sequence
    initial begin
        int guard;
        errors = 0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        cur_slot = '0; dead_anchor = '0; live_n = 0; id_next = '0; sys_time = '0;
        for (int s = 0; s < NSLOT; s++) begin
            ring_next[s] = '0; ring_prev[s] = '0; prio_tab[s] = '0;
            alive[s] = 0; asleep[s] = 0; blocked[s] = 0;
            wake_at[s] = '0; tid_tab[s] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1500);
        start <= 1'b0;
        guard = 0;
        while (pending_words.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2 * NSLOT + 10) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $error("%0d result words never arrived", pending_words.size());
            errors++;
        end
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: priority_round_robin_thread_scheduler.f
+incdir+rtl
rtl/prts_pkg.sv
rtl/prts_ram.sv
rtl/prts_ctrl.sv
rtl/prts_dp.sv
rtl/priority_round_robin_thread_scheduler.sv
sim/priority_round_robin_thread_scheduler_test.sv
